### rtl/core/cvfm_pkg.sv
// shared types, constants and register codes of the cell voltage fault monitor
package cvfm_pkg;

  // default geometry of the pack
  localparam int MODULES_DEF          = 6;
  localparam int CELLS_PER_MODULE_DEF = 14;
  localparam int TOTAL_CELLS_DEF      = 84;

  // fixed field widths
  localparam int VOLT_W   = 13;
  localparam int MODIDX_W = 3;
  localparam int POS_W    = 4;
  localparam int MASK_W   = 14;
  localparam int CNT_W    = 8;
  localparam int CFG_W    = 13;
  localparam int CFGIDX_W = 2;

  localparam logic [CNT_W-1:0] CNT_MAX = 8'd255;

  // register reset values
  localparam logic [VOLT_W-1:0] OVER_RST  = 13'd4200;
  localparam logic [VOLT_W-1:0] UNDER_RST = 13'd2500;
  localparam logic [CNT_W-1:0]  LIMIT_RST = 8'd3;

  // configuration register indexes
  typedef enum logic [CFGIDX_W-1:0] {
    CFG_OVER  = 2'd0,
    CFG_UNDER = 2'd1,
    CFG_LIMIT = 2'd2
  } cfg_reg_t;

  // input word
  typedef struct packed {
    logic [VOLT_W-1:0]   cell_voltage_mv;
    logic [MODIDX_W-1:0] module_index;
    logic [POS_W-1:0]    cell_position;
    logic                last_in_scan;
  } cvfm_in_t;

  // result word
  typedef struct packed {
    logic [MASK_W-1:0] module_over_mask;
    logic [MASK_W-1:0] module_under_mask;
    logic              pack_over_fault;
    logic              pack_under_fault;
    logic [CNT_W-1:0]  cell_fault_count;
    logic [VOLT_W-1:0] scan_max_mv;
    logic [VOLT_W-1:0] scan_min_mv;
    logic              scan_done;
  } cvfm_out_t;

  // per-cell counter status after the update
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             over_dir;
    logic             latched;
  } cvfm_cnt_stat_t;

endpackage

### rtl/core/cell_voltage_fault_monitor_top.sv
// top level of the cell voltage fault monitor: handshake, masks, pack flags, scan extremes
// an accepted word passes the stage register and then the result register to give its result
// one word per cycle unless the output stalls; the counter ram is read when a word is accepted
//   and written back when it leaves the stage reg, a bypass register covers back-to-back cells
// reset (rst, synchronous): clears handshake state, cell valid bits, masks, pack flags,
//   scan tracking and loads the threshold registers; no clearing pass, ready at once
module cell_voltage_fault_monitor_top
  import cvfm_pkg::*;
#(
  parameter int MODULES          = MODULES_DEF,
  parameter int CELLS_PER_MODULE = CELLS_PER_MODULE_DEF,
  parameter int TOTAL_CELLS      = TOTAL_CELLS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                sample_valid,
  output logic                sample_stall,
  input  cvfm_in_t            sample,
  output logic                result_valid,
  input  logic                result_stall,
  output cvfm_out_t           result,
  input  logic                cfg_we,
  input  logic [CFGIDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]    cfg_data
);

  localparam int MOD_W = (MODULES > 1) ? $clog2(MODULES) : 1;
  localparam int IDX_W = (TOTAL_CELLS > 1) ? $clog2(TOTAL_CELLS) : 1;
  localparam int FLAT_W = 8;

  // configuration registers
  logic [VOLT_W-1:0] over_voltage_mv;
  logic [VOLT_W-1:0] under_voltage_mv;
  logic [CNT_W-1:0]  fault_count_limit;

  // stage register
  logic                        s1_valid;
  cvfm_in_t                    s1_item;
  logic                        s1_mod_ok;
  logic                        s1_cell_ok;
  logic [IDX_W-1:0]            s1_idx;
  logic [MOD_W-1:0]            s1_mod;

  // pack state
  logic [CELLS_PER_MODULE-1:0] over_masks  [0:MODULES-1];
  logic [CELLS_PER_MODULE-1:0] under_masks [0:MODULES-1];
  logic                        pack_over_flag;
  logic                        pack_under_flag;
  logic [VOLT_W-1:0]           running_max;
  logic [VOLT_W-1:0]           running_min;
  logic                        scan_fresh;

  // stage 0 decode
  logic                        sample_accept;
  logic                        mod_ok0;
  logic                        pos_ok0;
  logic                        cell_ok0;
  logic [FLAT_W-1:0]           cell_flat0;

  // stage 1 compute
  logic                        out_free;
  logic                        s1_fire;
  cvfm_cnt_stat_t              cnt_stat;
  logic [CELLS_PER_MODULE-1:0] cell_bit;
  logic [CELLS_PER_MODULE-1:0] over_cur;
  logic [CELLS_PER_MODULE-1:0] under_cur;
  logic [CELLS_PER_MODULE-1:0] over_next;
  logic [CELLS_PER_MODULE-1:0] under_next;
  logic                        set_over;
  logic                        set_under;
  logic                        pack_over_next;
  logic                        pack_under_next;
  logic [VOLT_W-1:0]           max_next;
  logic [VOLT_W-1:0]           min_next;
  logic                        over_any;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      over_voltage_mv   <= OVER_RST;
      under_voltage_mv  <= UNDER_RST;
      fault_count_limit <= LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_OVER:  over_voltage_mv   <= cfg_data;
        CFG_UNDER: under_voltage_mv  <= cfg_data;
        CFG_LIMIT: fault_count_limit <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake
  assign out_free      = !result_valid || !result_stall;
  assign s1_fire       = s1_valid && out_free;
  assign sample_stall  = s1_valid && !out_free;
  assign sample_accept = sample_valid && !sample_stall;

  // cell address decode
  always_comb begin
    mod_ok0    = int'(sample.module_index) < MODULES;
    pos_ok0    = int'(sample.cell_position) < CELLS_PER_MODULE;
    cell_flat0 = FLAT_W'(FLAT_W'(sample.module_index) * FLAT_W'(CELLS_PER_MODULE))
               + FLAT_W'(sample.cell_position);
    cell_ok0   = mod_ok0 && pos_ok0 && (int'(cell_flat0) < TOTAL_CELLS);
  end

  // stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (sample_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_accept) begin
      s1_item    <= sample;
      s1_mod_ok  <= mod_ok0 && pos_ok0;
      s1_cell_ok <= cell_ok0;
      s1_idx     <= IDX_W'(cell_flat0);
      s1_mod     <= MOD_W'(sample.module_index);
    end
  end

  // fault counters
  cvfm_fault_count #(
    .TOTAL_CELLS (TOTAL_CELLS)
  ) u_fault_count (
    .clk               (clk),
    .rst               (rst),
    .rd_en             (sample_accept && cell_ok0),
    .rd_idx            (IDX_W'(cell_flat0)),
    .wr_en             (s1_fire && s1_cell_ok),
    .idx               (s1_idx),
    .voltage           (s1_item.cell_voltage_mv),
    .over_voltage_mv   (over_voltage_mv),
    .under_voltage_mv  (under_voltage_mv),
    .fault_count_limit (fault_count_limit),
    .stat              (cnt_stat)
  );

  // mask and pack flag update
  always_comb begin
    cell_bit  = CELLS_PER_MODULE'(1) << s1_item.cell_position;
    over_cur  = s1_mod_ok ? over_masks[s1_mod]  : '0;
    under_cur = s1_mod_ok ? under_masks[s1_mod] : '0;
    set_over  = s1_cell_ok && cnt_stat.latched && cnt_stat.over_dir;
    set_under = s1_cell_ok && cnt_stat.latched && !cnt_stat.over_dir;
    over_next  = over_cur  | (set_over  ? cell_bit : '0);
    under_next = under_cur | (set_under ? cell_bit : '0);
    pack_over_next  = pack_over_flag  || set_over;
    pack_under_next = pack_under_flag || set_under;
  end

  // scan extremes
  always_comb begin
    if (scan_fresh) begin
      max_next = s1_item.cell_voltage_mv;
      min_next = s1_item.cell_voltage_mv;
    end else begin
      max_next = (s1_item.cell_voltage_mv > running_max) ? s1_item.cell_voltage_mv
                                                          : running_max;
      min_next = (s1_item.cell_voltage_mv < running_min) ? s1_item.cell_voltage_mv
                                                          : running_min;
    end
  end

  // pack state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int m = 0; m < MODULES; m++) begin
        over_masks[m]  <= '0;
        under_masks[m] <= '0;
      end
      pack_over_flag  <= 1'b0;
      pack_under_flag <= 1'b0;
      running_max     <= '0;
      running_min     <= '0;
      scan_fresh      <= 1'b1;
    end else if (s1_fire) begin
      if (s1_mod_ok) begin
        over_masks[s1_mod]  <= over_next;
        under_masks[s1_mod] <= under_next;
      end
      pack_over_flag  <= pack_over_next;
      pack_under_flag <= pack_under_next;
      running_max     <= max_next;
      running_min     <= min_next;
      scan_fresh      <= s1_item.last_in_scan;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      result.module_over_mask  <= MASK_W'(over_next);
      result.module_under_mask <= MASK_W'(under_next);
      result.pack_over_fault   <= pack_over_next;
      result.pack_under_fault  <= pack_under_next;
      result.cell_fault_count  <= s1_cell_ok ? cnt_stat.count : '0;
      result.scan_max_mv       <= max_next;
      result.scan_min_mv       <= min_next;
      result.scan_done         <= s1_item.last_in_scan;
    end
  end

  // any over bit latched anywhere
  always_comb begin
    over_any = 1'b0;
    for (int m = 0; m < MODULES; m++) begin
      over_any = over_any || (|over_masks[m]);
    end
  end

  // stall only while the stage register holds a word
  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    sample_stall |-> s1_valid)
    else $error("input stalled with empty stage");

  // extremes stay ordered
  a_min_le_max: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.scan_min_mv <= result.scan_max_mv))
    else $error("scan minimum above maximum");

  // pack over flag is sticky
  a_pack_sticky: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> !$fell(pack_over_flag))
    else $error("pack over flag cleared");

  // a latched over bit implies the pack flag
  a_mask_flag: assert property (@(posedge clk) disable iff (rst)
    over_any |-> pack_over_flag)
    else $error("over mask bit without pack flag");

endmodule

### rtl/core/cvfm_ram.sv
// generic single write port ram with registered read
module cvfm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, holds when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/core/cvfm_fault_count.sv
// per-cell up/down fault counters with direction, kept in ram with valid bits and bypass
module cvfm_fault_count
  import cvfm_pkg::*;
#(
  parameter int TOTAL_CELLS = TOTAL_CELLS_DEF,
  localparam int IDX_W = (TOTAL_CELLS > 1) ? $clog2(TOTAL_CELLS) : 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  rd_en,
  input  logic [IDX_W-1:0]      rd_idx,
  input  logic                  wr_en,
  input  logic [IDX_W-1:0]      idx,
  input  logic [VOLT_W-1:0]     voltage,
  input  logic [VOLT_W-1:0]     over_voltage_mv,
  input  logic [VOLT_W-1:0]     under_voltage_mv,
  input  logic [CNT_W-1:0]      fault_count_limit,
  output cvfm_cnt_stat_t        stat
);

  localparam int ENTRY_W = CNT_W + 1;

  logic [ENTRY_W-1:0]     rdata;
  logic [ENTRY_W-1:0]     cur_entry;
  logic [ENTRY_W-1:0]     new_entry;
  logic [TOTAL_CELLS-1:0] cell_valid;
  logic                   byp_valid;
  logic [IDX_W-1:0]       byp_idx;
  logic [ENTRY_W-1:0]     byp_data;
  logic [CNT_W-1:0]       cur_cnt;
  logic                   cur_dir;
  logic [CNT_W-1:0]       cnt_new;
  logic                   dir_new;

  // entry store: {direction, count}
  cvfm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TOTAL_CELLS)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (idx),
    .wdata (new_entry),
    .re    (rd_en),
    .raddr (rd_idx),
    .rdata (rdata)
  );

  // current entry: last write wins over the ram read, unwritten cells read zero
  always_comb begin
    if (byp_valid && (byp_idx == idx)) begin
      cur_entry = byp_data;
    end else if (cell_valid[idx]) begin
      cur_entry = rdata;
    end else begin
      cur_entry = '0;
    end
    cur_dir = cur_entry[CNT_W];
    cur_cnt = cur_entry[CNT_W-1:0];
  end

  // counter update, over test first
  always_comb begin
    cnt_new = cur_cnt;
    dir_new = cur_dir;
    if (voltage > over_voltage_mv) begin
      if (cur_cnt != CNT_MAX) begin
        cnt_new = cur_cnt + 1'b1;
      end
      dir_new = 1'b1;
    end else if (voltage < under_voltage_mv) begin
      if (cur_cnt != CNT_MAX) begin
        cnt_new = cur_cnt + 1'b1;
      end
      dir_new = 1'b0;
    end else if (cur_cnt != '0) begin
      cnt_new = cur_cnt - 1'b1;
    end
    new_entry     = {dir_new, cnt_new};
    stat.count    = cnt_new;
    stat.over_dir = dir_new;
    stat.latched  = (cnt_new > fault_count_limit);
  end

  // valid bits and bypass of the most recent write
  always_ff @(posedge clk) begin
    if (rst) begin
      cell_valid <= '0;
      byp_valid  <= 1'b0;
    end else if (wr_en) begin
      cell_valid[idx] <= 1'b1;
      byp_valid       <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      byp_idx  <= idx;
      byp_data <= new_entry;
    end
  end

  // a saturated counter never goes past the maximum, so a limit at the maximum never latches
  a_no_latch_at_max: assert property (@(posedge clk) disable iff (rst)
    wr_en && (fault_count_limit == CNT_MAX) |-> !stat.latched)
    else $error("cell latched with limit at counter maximum");

endmodule
